/* sv/lpet_pkg.sv */
// ----------------------------------------------------------------------------
// lpet_pkg
// Shared constants for the logo presence edge test: frame geometry, window
// radius, mask store size, counter width and register map.
// ----------------------------------------------------------------------------
package lpet_pkg;

  // line geometry
  localparam int MAX_WIDTH = 512;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WID_W     = COL_W + 1;
  localparam int ROW_W     = 9;

  // cross window radius and the lines kept for it
  localparam int RADIUS    = 2;
  localparam int NLINES    = 2 * RADIUS;
  localparam int LSEL_W    = $clog2(NLINES);
  localparam int LWORD_W   = NLINES * 8;

  // stored edge mask
  localparam int MASK_DEPTH = 131072;
  localparam int MASK_AW    = $clog2(MASK_DEPTH);

  // frame counters, saturating
  localparam int ACC_W = 19;
  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  // command codes carried in tuser
  localparam logic CMD_MASK  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  // register indexes, byte address = 4 * index
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_BOX_LEFT    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BOX_RIGHT   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BOX_TOP     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BOX_BOTTOM  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_EDGE_DIFF   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_GOOD_THRESH = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_BAD_THRESH  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd7;

endpackage

/* sv/lpet_ram.sv */
// ----------------------------------------------------------------------------
// lpet_ram
// Generic single-write, single-read synchronous RAM with registered read
// data. A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module lpet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/logo_presence_edge_test_top.sv */
// ----------------------------------------------------------------------------
// logo_presence_edge_test_top
// Compares the edges of one luma frame inside a box against a stored edge
// mask and reports whether the logo is present.
// ----------------------------------------------------------------------------
// Usage: after reset the block clears its line buffers with s_axis_tready
// low (register writes are taken during that time). It then takes one word
// per clock unless stalled: mask entries (tuser 0) go straight into the mask
// store, pixels (tuser 1) in raster order with tlast on the last pixel of the
// frame. Each pixel reads the four buffered lines at its column and at its
// column plus two in the same cycle, from two line buffer copies, and the
// stage 1 registers write its word back, so the sustained rate is one pixel
// per clock. The frame result passes the stage 1, stage 2, snapshot, product
// and output registers to m_axis; input stalls only when a result is blocked
// while two more results wait behind it.
// ----------------------------------------------------------------------------
module logo_presence_edge_test_top (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // mask_addr[16:0], mask_horiz, mask_vert, luma[7:0]
  input  logic        s_axis_tuser,  // cmd
  input  logic        s_axis_tlast,  // frame_end
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // logo_present, good_count[18:0], bad_count[18:0],
                                     // edge_tests[18:0], non_edge_tests[18:0]
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PROD_W = lpet_pkg::ACC_W + 9;
  localparam int SH_W   = lpet_pkg::ACC_W + 8;

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  logic [8:0] box_left, box_right, box_top, box_bottom;
  logic [7:0] edge_diff;
  logic [8:0] good_threshold, bad_threshold;
  logic [9:0] frame_width;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_left       <= 9'd4;
      box_right      <= 9'd4;
      box_top        <= 9'd4;
      box_bottom     <= 9'd4;
      edge_diff      <= 8'd5;
      good_threshold <= 9'd192;
      bad_threshold  <= 9'd218;
      frame_width    <= 10'd480;
    end else if (cfg_write) begin
      case (paddr[4:2])
        lpet_pkg::REG_BOX_LEFT:    box_left       <= pwdata[8:0];
        lpet_pkg::REG_BOX_RIGHT:   box_right      <= pwdata[8:0];
        lpet_pkg::REG_BOX_TOP:     box_top        <= pwdata[8:0];
        lpet_pkg::REG_BOX_BOTTOM:  box_bottom     <= pwdata[8:0];
        lpet_pkg::REG_EDGE_DIFF:   edge_diff      <= pwdata[7:0];
        lpet_pkg::REG_GOOD_THRESH: good_threshold <= pwdata[8:0];
        lpet_pkg::REG_BAD_THRESH:  bad_threshold  <= pwdata[8:0];
        lpet_pkg::REG_FRAME_WIDTH: frame_width    <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[4:2])
      lpet_pkg::REG_BOX_LEFT:    prdata = 32'(box_left);
      lpet_pkg::REG_BOX_RIGHT:   prdata = 32'(box_right);
      lpet_pkg::REG_BOX_TOP:     prdata = 32'(box_top);
      lpet_pkg::REG_BOX_BOTTOM:  prdata = 32'(box_bottom);
      lpet_pkg::REG_EDGE_DIFF:   prdata = 32'(edge_diff);
      lpet_pkg::REG_GOOD_THRESH: prdata = 32'(good_threshold);
      lpet_pkg::REG_BAD_THRESH:  prdata = 32'(bad_threshold);
      lpet_pkg::REG_FRAME_WIDTH: prdata = 32'(frame_width);
      default:                   prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------
  function automatic logic hit_test(input logic [7:0] a, input logic [7:0] b,
                                    input logic [7:0] c, input logic [7:0] thr);
    logic [7:0] da, db;
    da = (a > c) ? a - c : c - a;
    db = (b > c) ? b - c : c - b;
    return (da >= thr) || (db >= thr);
  endfunction

  function automatic logic [lpet_pkg::ACC_W-1:0] sat_add(
      input logic [lpet_pkg::ACC_W-1:0] a, input logic [1:0] inc);
    logic [lpet_pkg::ACC_W:0] sum;
    sum = {1'b0, a} + (lpet_pkg::ACC_W+1)'(inc);
    if (sum > (lpet_pkg::ACC_W+1)'(lpet_pkg::ACC_MAX)) begin
      return lpet_pkg::ACC_MAX;
    end
    return sum[lpet_pkg::ACC_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // pipeline flow control
  // --------------------------------------------------------------------------
  logic snap_valid, prod_valid;
  logic out_ready, prod_ready, snap_ready, adv;
  logic [lpet_pkg::COL_W:0] clr_cnt;
  logic clr_busy, accept;

  assign out_ready     = !m_axis_tvalid || m_axis_tready;
  assign prod_ready    = !prod_valid || out_ready;
  assign snap_ready    = !snap_valid || prod_ready;
  assign adv           = snap_ready;
  assign clr_busy      = !clr_cnt[lpet_pkg::COL_W];
  assign s_axis_tready = adv && !clr_busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // line buffer clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clr_busy) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: position, window control, memory reads
  // --------------------------------------------------------------------------
  logic [16:0] in_mask_addr;
  logic        in_horiz, in_vert, in_pixel;
  logic [7:0]  in_luma;

  assign in_mask_addr = s_axis_tdata[16:0];
  assign in_horiz     = s_axis_tdata[17];
  assign in_vert      = s_axis_tdata[18];
  assign in_luma      = s_axis_tdata[26:19];
  assign in_pixel     = (s_axis_tuser == lpet_pkg::CMD_PIXEL);

  logic [lpet_pkg::COL_W-1:0] col, col_next;
  logic [lpet_pkg::ROW_W-1:0] row, row_next;
  logic [lpet_pkg::WID_W-1:0] w_eff, col_inc;
  logic [lpet_pkg::ROW_W-1:0] cy;
  logic [lpet_pkg::COL_W-1:0] col_ahead;
  logic                       in_box, right_ok;
  logic [lpet_pkg::ROW_W+lpet_pkg::WID_W-1:0] row_base;
  logic [lpet_pkg::ROW_W+lpet_pkg::WID_W:0]   mask_lin;
  logic [lpet_pkg::MASK_AW-1:0]               mask_raddr;

  // effective width clamped to one line buffer
  always_comb begin
    if (frame_width == '0) begin
      w_eff = lpet_pkg::WID_W'(1);
    end else if (frame_width > 10'(lpet_pkg::MAX_WIDTH)) begin
      w_eff = lpet_pkg::WID_W'(lpet_pkg::MAX_WIDTH);
    end else begin
      w_eff = lpet_pkg::WID_W'(frame_width);
    end
  end

  assign cy        = row - lpet_pkg::ROW_W'(lpet_pkg::RADIUS);
  assign col_ahead = col + lpet_pkg::COL_W'(lpet_pkg::RADIUS);
  assign col_inc   = {1'b0, col} + 1'b1;
  assign in_box    = (row >= lpet_pkg::ROW_W'(lpet_pkg::RADIUS))
                     && (cy >= box_top) && (cy <= box_bottom)
                     && (col >= box_left) && (col <= box_right);
  assign right_ok  = ((lpet_pkg::WID_W+1)'(col) + (lpet_pkg::WID_W+1)'(lpet_pkg::RADIUS))
                     < (lpet_pkg::WID_W+1)'(w_eff);

  // mask index of the window centre
  assign row_base   = (lpet_pkg::ROW_W+lpet_pkg::WID_W)'(cy)
                      * (lpet_pkg::ROW_W+lpet_pkg::WID_W)'(w_eff);
  assign mask_lin   = {1'b0, row_base} + (lpet_pkg::ROW_W+lpet_pkg::WID_W+1)'(col);
  assign mask_raddr = mask_lin[lpet_pkg::MASK_AW-1:0];

  // raster position
  always_comb begin
    col_next = col;
    row_next = row;
    if (s_axis_tlast) begin
      col_next = '0;
      row_next = '0;
    end else if (col_inc >= w_eff) begin
      col_next = '0;
      row_next = row + 1'b1;
    end else begin
      col_next = col_inc[lpet_pkg::COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept && in_pixel) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // --------------------------------------------------------------------------
  // memories
  // --------------------------------------------------------------------------
  logic                         s1_valid;
  logic [lpet_pkg::COL_W-1:0]   s1_col;
  logic [lpet_pkg::LWORD_W-1:0] line_wdata, rd_a, rd_b;
  logic                         line_we;
  logic [lpet_pkg::COL_W-1:0]   line_waddr;
  logic [lpet_pkg::LWORD_W-1:0] line_wword;
  logic [1:0]                   mask_rdata;

  assign line_we    = clr_busy || (s1_valid && adv);
  assign line_waddr = clr_busy ? clr_cnt[lpet_pkg::COL_W-1:0] : s1_col;
  assign line_wword = clr_busy ? '0 : line_wdata;

  lpet_ram #(.WIDTH(2), .DEPTH(lpet_pkg::MASK_DEPTH)) u_mask_ram (
    .clk   (clk),
    .we    (accept && !in_pixel),
    .waddr (in_mask_addr[lpet_pkg::MASK_AW-1:0]),
    .wdata ({in_vert, in_horiz}),
    .re    (accept && in_pixel),
    .raddr (mask_raddr),
    .rdata (mask_rdata)
  );

  // line buffers, one copy read at the centre column, one two columns ahead
  lpet_ram #(.WIDTH(lpet_pkg::LWORD_W), .DEPTH(lpet_pkg::MAX_WIDTH)) u_line_ram_a (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_wword),
    .re    (accept && in_pixel),
    .raddr (col),
    .rdata (rd_a)
  );

  lpet_ram #(.WIDTH(lpet_pkg::LWORD_W), .DEPTH(lpet_pkg::MAX_WIDTH)) u_line_ram_b (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_wword),
    .re    (accept && in_pixel),
    .raddr (col_ahead),
    .rdata (rd_b)
  );

  // --------------------------------------------------------------------------
  // stage 1 registers
  // --------------------------------------------------------------------------
  logic [lpet_pkg::LSEL_W-1:0]  s1_wsel;
  logic                         s1_test, s1_left_ok, s1_right_ok, s1_up_ok, s1_fe;
  logic [7:0]                   s1_luma;
  logic                         fwd_a, fwd_b;
  logic [lpet_pkg::LWORD_W-1:0] fwd_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept && in_pixel;
    end
  end

  // the previous word is written back in the same cycle as these reads
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_col      <= col;
      s1_wsel     <= row[lpet_pkg::LSEL_W-1:0];
      s1_test     <= in_box;
      s1_left_ok  <= (col >= lpet_pkg::COL_W'(lpet_pkg::RADIUS));
      s1_right_ok <= right_ok;
      s1_up_ok    <= (row >= lpet_pkg::ROW_W'(lpet_pkg::NLINES));
      s1_luma     <= in_luma;
      s1_fe       <= s_axis_tlast;
      fwd_a       <= s1_valid && (col == s1_col);
      fwd_b       <= s1_valid && (col_ahead == s1_col);
      fwd_word    <= line_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: window assembly, edge tests, write-back word
  // --------------------------------------------------------------------------
  logic [lpet_pkg::LWORD_W-1:0] word_a, word_b;
  logic [lpet_pkg::LSEL_W-1:0]  s1_csel;
  logic [7:0] ctr, up_px, left_px, right_px;
  logic [7:0] ctr_hist [lpet_pkg::RADIUS];
  logic       hit_h, hit_v;

  assign word_a  = fwd_a ? fwd_word : rd_a;
  assign word_b  = fwd_b ? fwd_word : rd_b;
  assign s1_csel = s1_wsel - lpet_pkg::LSEL_W'(lpet_pkg::RADIUS);

  assign ctr      = word_a[{s1_csel, 3'b000} +: 8];
  assign up_px    = s1_up_ok ? word_a[{s1_wsel, 3'b000} +: 8] : 8'd0;
  assign left_px  = s1_left_ok ? ctr_hist[lpet_pkg::RADIUS-1] : 8'd0;
  assign right_px = s1_right_ok ? word_b[{s1_csel, 3'b000} +: 8] : 8'd0;
  assign hit_h    = hit_test(left_px, right_px, ctr, edge_diff);
  assign hit_v    = hit_test(up_px, s1_luma, ctr, edge_diff);

  // replace the oldest line byte with the new pixel
  always_comb begin
    line_wdata = word_a;
    for (int i = 0; i < lpet_pkg::NLINES; i++) begin
      if (s1_wsel == lpet_pkg::LSEL_W'(i)) begin
        line_wdata[i*8 +: 8] = s1_luma;
      end
    end
  end

  // centre values of the last pixels, for the left neighbor
  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      ctr_hist[0] <= ctr;
      for (int i = 1; i < lpet_pkg::RADIUS; i++) begin
        ctr_hist[i] <= ctr_hist[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: frame counters
  // --------------------------------------------------------------------------
  logic s2_valid, s2_test, s2_fe, s2_hit_h, s2_hit_v, s2_mark_h, s2_mark_v;
  logic [lpet_pkg::ACC_W-1:0] good_acc, bad_acc, edge_test_acc, non_edge_test_acc;
  logic [lpet_pkg::ACC_W-1:0] good_next, bad_next, edge_next, non_edge_next;
  logic [1:0] inc_good, inc_bad, inc_edge, inc_non_edge;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_test   <= s1_test;
      s2_fe     <= s1_fe;
      s2_hit_h  <= hit_h;
      s2_hit_v  <= hit_v;
      s2_mark_h <= mask_rdata[0];
      s2_mark_v <= mask_rdata[1];
    end
  end

  always_comb begin
    inc_good     = '0;
    inc_bad      = '0;
    inc_edge     = '0;
    inc_non_edge = '0;
    if (s2_test) begin
      inc_good     = 2'(s2_mark_h && s2_hit_h) + 2'(s2_mark_v && s2_hit_v);
      inc_bad      = 2'(!s2_mark_h && s2_hit_h) + 2'(!s2_mark_v && s2_hit_v);
      inc_edge     = 2'(s2_mark_h) + 2'(s2_mark_v);
      inc_non_edge = 2'(!s2_mark_h) + 2'(!s2_mark_v);
    end
  end

  assign good_next     = sat_add(good_acc, inc_good);
  assign bad_next      = sat_add(bad_acc, inc_bad);
  assign edge_next     = sat_add(edge_test_acc, inc_edge);
  assign non_edge_next = sat_add(non_edge_test_acc, inc_non_edge);

  always_ff @(posedge clk) begin
    if (rst) begin
      good_acc          <= '0;
      bad_acc           <= '0;
      edge_test_acc     <= '0;
      non_edge_test_acc <= '0;
    end else if (adv && s2_valid) begin
      if (s2_fe) begin
        good_acc          <= '0;
        bad_acc           <= '0;
        edge_test_acc     <= '0;
        non_edge_test_acc <= '0;
      end else begin
        good_acc          <= good_next;
        bad_acc           <= bad_next;
        edge_test_acc     <= edge_next;
        non_edge_test_acc <= non_edge_next;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result path: snapshot, products, compare
  // --------------------------------------------------------------------------
  logic [lpet_pkg::ACC_W-1:0] snap_good, snap_bad, snap_edge, snap_non_edge;
  logic [lpet_pkg::ACC_W-1:0] prod_good, prod_bad, prod_edge, prod_non_edge;
  logic [PROD_W-1:0]          good_rhs, bad_rhs;
  logic                       edge_zero, non_edge_zero, bad_thr_nz;
  logic                       good_ok, bad_ok;

  // snapshot of the finished frame
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (adv && s2_valid && s2_fe) begin
      snap_valid <= 1'b1;
    end else if (prod_ready) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid && s2_fe) begin
      snap_good     <= good_next;
      snap_bad      <= bad_next;
      snap_edge     <= edge_next;
      snap_non_edge <= non_edge_next;
    end
  end

  // threshold products
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (prod_ready) begin
      prod_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready) begin
      prod_good     <= snap_good;
      prod_bad      <= snap_bad;
      prod_edge     <= snap_edge;
      prod_non_edge <= snap_non_edge;
      good_rhs      <= PROD_W'(good_threshold) * PROD_W'(snap_edge);
      bad_rhs       <= PROD_W'(bad_threshold) * PROD_W'(snap_non_edge);
      edge_zero     <= (snap_edge == '0);
      non_edge_zero <= (snap_non_edge == '0);
      bad_thr_nz    <= (bad_threshold != '0);
    end
  end

  // ratio tests, zero test count means ratio zero
  assign good_ok = !edge_zero && (PROD_W'({prod_good, 8'd0}) > good_rhs);
  assign bad_ok  = non_edge_zero ? bad_thr_nz : (PROD_W'({prod_bad, 8'd0}) < bad_rhs);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_axis_tvalid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && prod_valid) begin
      m_axis_tdata <= {3'b000, prod_non_edge, prod_edge, prod_bad, prod_good,
                       good_ok && bad_ok};
    end
  end

endmodule

/* bench/logo_presence_edge_test_top_tb.sv */
// ----------------------------------------------------------------------------
// logo_presence_edge_test_top_tb
// Self-checking bench for the logo presence edge test. Mask entries and
// luma frames are streamed in, and each accepted word is run through a local
// model of the cross-window edge counts. Every frame verdict that comes out
// is compared field by field with the model's prediction. Box, threshold,
// edge and width registers are reprogrammed between groups of frames, and
// the sender and receiver idle at random in rotating phases.
// ----------------------------------------------------------------------------
module logo_presence_edge_test_top_tb;
  import lpet_pkg::*;

  localparam int ROW_SPAN = 1 << ROW_W;

  // kinds of frame content
  localparam int LUMA_RANDOM  = 0;
  localparam int LUMA_FLAT    = 1;
  localparam int LUMA_STRIPES = 2;
  localparam int LUMA_EXTREME = 3;

  // kinds of mask content
  localparam int MASK_CLEAR = 0;
  localparam int MASK_FULL  = 1;
  localparam int MASK_MIXED = 2;
  localparam int MASK_HORIZ = 3;

  // one input word before packing
  typedef struct packed {
    logic        cmd;
    logic        last;
    logic [7:0]  luma;
    logic        vert;
    logic        horiz;
    logic [16:0] addr;
  } word_t;

  // one frame verdict, laid out as on m_axis_tdata
  typedef struct packed {
    logic [ACC_W-1:0] non_edge_tests;
    logic [ACC_W-1:0] edge_tests;
    logic [ACC_W-1:0] bad_count;
    logic [ACC_W-1:0] good_count;
    logic             logo_present;
  } frame_verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // mask_addr[16:0], mask_horiz, mask_vert, luma[7:0]
  logic        s_axis_tuser = 1'b0;  // cmd
  logic        s_axis_tlast = 1'b0;  // frame_end
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;  // logo_present, good_count, bad_count, edge_tests,
                              // non_edge_tests
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logo_presence_edge_test_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk = ~clk;

  // register shadow, shared by the frame planner and the edge model
  logic [8:0] box_l = 9'd4;
  logic [8:0] box_r = 9'd4;
  logic [8:0] box_t = 9'd4;
  logic [8:0] box_b = 9'd4;
  logic [7:0] min_diff = 8'd5;
  logic [8:0] good_thr = 9'd192;
  logic [8:0] bad_thr = 9'd218;
  logic [9:0] frame_w = 10'd480;

  // edge model state
  bit [1:0]       mask_mem [MASK_DEPTH];
  bit [7:0]       line_mem [NLINES][MAX_WIDTH];
  int unsigned    col_pos = 0;
  int unsigned    row_pos = 0;
  bit [ACC_W-1:0] n_good = '0;
  bit [ACC_W-1:0] n_bad = '0;
  bit [ACC_W-1:0] n_edge_tests = '0;
  bit [ACC_W-1:0] n_plain_tests = '0;

  frame_verdict_t verdicts [$];
  word_t          to_send [$];
  word_t          next_word;

  // position the frame planner expects the block to be at
  int unsigned gen_col = 0;
  int unsigned gen_row = 0;
  int          items_queued = 0;
  int          frames_queued = 0;
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  function automatic int unsigned eff_width();
    if (frame_w == 0) return 1;
    if (frame_w > MAX_WIDTH) return MAX_WIDTH;
    return frame_w;
  endfunction

  function automatic bit in_box(input int unsigned cy, input int unsigned c);
    return cy >= box_t && cy <= box_b && c >= box_l && c <= box_r;
  endfunction

  function automatic bit is_edge(input int a, input int b, input int ctr);
    int da;
    int db;
    da = (a > ctr) ? a - ctr : ctr - a;
    db = (b > ctr) ? b - ctr : ctr - b;
    return da >= min_diff || db >= min_diff;
  endfunction

  // saturating tally of one test
  function automatic void tally(input bit marked, input bit hit);
    if (marked) begin
      if (hit && n_good != ACC_MAX) n_good = n_good + 1'b1;
      if (n_edge_tests != ACC_MAX) n_edge_tests = n_edge_tests + 1'b1;
    end else begin
      if (hit && n_bad != ACC_MAX) n_bad = n_bad + 1'b1;
      if (n_plain_tests != ACC_MAX) n_plain_tests = n_plain_tests + 1'b1;
    end
  endfunction

  // advance the edge model by one accepted word
  task automatic take_word(input logic cmd, input logic [31:0] d, input logic last);
    int unsigned    w;
    int unsigned    c;
    int unsigned    r;
    int unsigned    cy;
    int             lf;
    int             rt;
    bit [7:0]       column_slice [2*RADIUS+1];
    bit [1:0]       m;
    longint         g64;
    longint         b64;
    bit             good_ok;
    bit             bad_ok;
    frame_verdict_t v;
    if (cmd == CMD_MASK) begin
      mask_mem[d[16:0]] = d[18:17];
    end else begin
      w = eff_width();
      c = col_pos % MAX_WIDTH;
      r = row_pos;
      // vertical slice at this column, oldest row first
      for (int k = 0; k < 2 * RADIUS; k++)
        column_slice[k] = (r + k >= 2 * RADIUS) ?
                          line_mem[(r + k - 2 * RADIUS) % NLINES][c] : 8'd0;
      column_slice[2*RADIUS] = d[26:19];
      // test the centre two rows up
      if (r >= RADIUS) begin
        cy = r - RADIUS;
        if (in_box(cy, c)) begin
          lf = (c >= RADIUS) ? line_mem[cy % NLINES][c - RADIUS] : 0;
          rt = (c + RADIUS < w) ? line_mem[cy % NLINES][c + RADIUS] : 0;
          m = mask_mem[(cy * w + c) % MASK_DEPTH];
          tally(m[0], is_edge(lf, rt, column_slice[RADIUS]));
          tally(m[1], is_edge(column_slice[0], column_slice[2*RADIUS],
                              column_slice[RADIUS]));
        end
      end
      line_mem[r % NLINES][c] = d[26:19];
      if (last) begin
        // ratio tests, exact in integers
        g64 = n_good;
        b64 = n_bad;
        good_ok = (n_edge_tests != 0) && (g64 * 256 > longint'(good_thr) * n_edge_tests);
        if (n_plain_tests == 0) bad_ok = (bad_thr != 0);
        else bad_ok = b64 * 256 < longint'(bad_thr) * n_plain_tests;
        v.logo_present = good_ok && bad_ok;
        v.good_count = n_good;
        v.bad_count = n_bad;
        v.edge_tests = n_edge_tests;
        v.non_edge_tests = n_plain_tests;
        verdicts.push_back(v);
        n_good = '0;
        n_bad = '0;
        n_edge_tests = '0;
        n_plain_tests = '0;
        col_pos = 0;
        row_pos = 0;
      end else if (c + 1 >= w) begin
        col_pos = 0;
        row_pos = (r + 1) % ROW_SPAN;
      end else begin
        col_pos = c + 1;
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [ACC_W-1:0] want,
                               input logic [ACC_W-1:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("mismatch in %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // sender: next word from the queue, with random idle cycles
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_word = to_send.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'b0, next_word.luma, next_word.vert, next_word.horiz,
                         next_word.addr};
        s_axis_tuser <= next_word.cmd;
        s_axis_tlast <= next_word.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // input side: feed every accepted word to the model
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready)
      take_word(s_axis_tuser, s_axis_tdata, s_axis_tlast);
  end

  // result side: random stalls, check each accepted verdict
  always @(posedge clk) begin : result_check
    frame_verdict_t got;
    frame_verdict_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(frame_verdict_t)-1:0];
        if (verdicts.size() == 0) begin
          errors++;
          if (errors <= 10) $display("verdict with none expected: %h", got);
        end else begin
          want = verdicts.pop_front();
          compare_field("logo_present", want.logo_present, got.logo_present);
          compare_field("good_count", want.good_count, got.good_count);
          compare_field("bad_count", want.bad_count, got.bad_count);
          compare_field("edge_tests", want.edge_tests, got.edge_tests);
          compare_field("non_edge_tests", want.non_edge_tests, got.non_edge_tests);
        end
      end
    end
  end

  // register write: setup then access, upper bits sometimes junk
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
    logic [31:0] data;
    data = value;
    if ($urandom_range(3) == 0) data[31:10] = $urandom;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_BOX_LEFT:    box_l = data[8:0];
      REG_BOX_RIGHT:   box_r = data[8:0];
      REG_BOX_TOP:     box_t = data[8:0];
      REG_BOX_BOTTOM:  box_b = data[8:0];
      REG_EDGE_DIFF:   min_diff = data[7:0];
      REG_GOOD_THRESH: good_thr = data[8:0];
      REG_BAD_THRESH:  bad_thr = data[8:0];
      REG_FRAME_WIDTH: frame_w = data[9:0];
      default: ;
    endcase
  endtask

  // random inclusive span, now and then empty or running to the far end
  task automatic write_span(input logic [REG_IDX_W-1:0] lo_idx,
                            input logic [REG_IDX_W-1:0] hi_idx, input int unsigned limit);
    int unsigned a;
    int unsigned b;
    int unsigned t;
    a = $urandom_range(0, limit);
    b = $urandom_range(0, limit);
    if (a > b && $urandom_range(7) != 0) begin
      t = a;
      a = b;
      b = t;
    end
    if ($urandom_range(5) == 0) b = 511;
    write_reg(lo_idx, a);
    write_reg(hi_idx, b);
  endtask

  function automatic int unsigned pick_ratio();
    case ($urandom_range(5))
      0: return 0;
      1: return 256;
      default: return $urandom_range(1, 255);
    endcase
  endfunction

  function automatic word_t random_word(input logic cmd);
    word_t wd;
    wd.cmd = cmd;
    wd.last = (cmd == CMD_MASK) ? $urandom_range(1) : 1'b0;
    wd.luma = $urandom;
    wd.vert = $urandom_range(1);
    wd.horiz = $urandom_range(1);
    wd.addr = $urandom;
    return wd;
  endfunction

  // queue a run of pixels, preceded by writes of every mask entry it reads
  task automatic queue_frame(input int n_pix, input bit closes, input int luma_mode,
                             input int mask_mode);
    int unsigned centres [$];
    int unsigned w;
    int unsigned c;
    int unsigned r;
    word_t       wd;
    logic [7:0]  level;
    @(negedge clk);
    w = eff_width();
    level = $urandom_range(0, 252);
    // walk the positions the block will take
    for (int i = 0; i < n_pix; i++) begin
      c = gen_col % MAX_WIDTH;
      r = gen_row;
      if (r >= RADIUS && in_box(r - RADIUS, c))
        centres.push_back(((r - RADIUS) * w + c) % MASK_DEPTH);
      if (closes && i == n_pix - 1) begin
        gen_col = 0;
        gen_row = 0;
      end else if (c + 1 >= w) begin
        gen_col = 0;
        gen_row = (r + 1) % ROW_SPAN;
      end else begin
        gen_col = c + 1;
      end
    end
    // mask entries first
    foreach (centres[j]) begin
      wd = random_word(CMD_MASK);
      wd.addr = centres[j];
      wd.last = 1'b0;
      case (mask_mode)
        MASK_CLEAR: {wd.vert, wd.horiz} = 2'b00;
        MASK_FULL:  {wd.vert, wd.horiz} = 2'b11;
        MASK_HORIZ: wd.horiz = 1'b1;
        default: ;
      endcase
      to_send.push_back(wd);
    end
    items_queued += centres.size();
    // pixels, with a stray mask write now and then
    for (int i = 0; i < n_pix; i++) begin
      if ($urandom_range(24) == 0) begin
        to_send.push_back(random_word(CMD_MASK));
        items_queued++;
      end
      wd = random_word(CMD_PIXEL);
      case (luma_mode)
        LUMA_FLAT:    wd.luma = level + $urandom_range(0, 3);
        LUMA_STRIPES: wd.luma = (i % 3 == 0) ? 8'hFF : 8'h00;
        LUMA_EXTREME: wd.luma = $urandom_range(1) ? 8'hFF : 8'h00;
        default: ;
      endcase
      wd.last = closes && (i == n_pix - 1);
      to_send.push_back(wd);
    end
    items_queued += n_pix;
    if (closes) frames_queued++;
  endtask

  // hold off until every word is in and every verdict is out
  task automatic wait_quiet();
    do @(negedge clk);
    while (to_send.size() != 0 || s_axis_tvalid || verdicts.size() != 0);
    repeat (12) @(negedge clk);
  endtask

  function automatic void set_idle(input int phase);
    case (phase)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
      default: begin send_idle_pct = 18; recv_stall_pct = 18; end
    endcase
  endfunction

  initial begin
    int          grp;
    int unsigned w;
    int          rows;
    int          n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // frame touching both side borders, luma only 0 or 255
    set_idle(0);
    write_reg(REG_FRAME_WIDTH, 5);
    write_reg(REG_BOX_LEFT, 0);
    write_reg(REG_BOX_RIGHT, 4);
    write_reg(REG_BOX_TOP, 0);
    write_reg(REG_BOX_BOTTOM, 0);
    write_reg(REG_EDGE_DIFF, 255);
    write_reg(REG_GOOD_THRESH, 0);
    write_reg(REG_BAD_THRESH, 256);
    next_word = random_word(CMD_MASK);
    next_word.addr = 17'h1FFFF;
    to_send.push_back(next_word);
    queue_frame(15, 1'b1, LUMA_EXTREME, MASK_MIXED);
    wait_quiet();

    // empty box, one-pixel frame: no tests at all
    write_reg(REG_BOX_LEFT, 3);
    write_reg(REG_BOX_RIGHT, 1);
    queue_frame(1, 1'b1, LUMA_RANDOM, MASK_MIXED);
    wait_quiet();

    // width shrinks mid-frame, leaving the column past the line end
    write_reg(REG_FRAME_WIDTH, 12);
    write_reg(REG_BOX_LEFT, 6);
    write_reg(REG_BOX_RIGHT, 11);
    write_reg(REG_BOX_BOTTOM, 1);
    write_reg(REG_EDGE_DIFF, 20);
    queue_frame(33, 1'b0, LUMA_RANDOM, MASK_MIXED);
    wait_quiet();
    write_reg(REG_FRAME_WIDTH, 6);
    queue_frame(20, 1'b1, LUMA_RANDOM, MASK_MIXED);

    // random groups of frames, each under its own register setting
    for (grp = 0; items_queued < 1700 || frames_queued < 40 || grp < 8; grp++) begin
      wait_quiet();
      set_idle(grp % 4);
      write_reg(REG_EDGE_DIFF, $urandom_range(2) == 0 ? $urandom_range(255) :
                               $urandom_range(0, 60));
      write_reg(REG_GOOD_THRESH, pick_ratio());
      write_reg(REG_BAD_THRESH, pick_ratio());
      if (grp == 3) begin
        // widest line, width register clamped or exact
        write_reg(REG_FRAME_WIDTH, $urandom_range(1) ? 1023 : 512);
        write_reg(REG_BOX_LEFT, 0);
        write_reg(REG_BOX_RIGHT, 15);
        write_reg(REG_BOX_TOP, 0);
        write_reg(REG_BOX_BOTTOM, 0);
        queue_frame(2 * MAX_WIDTH + 20, 1'b1, LUMA_RANDOM, MASK_MIXED);
      end else if (grp == 6) begin
        // zero width reads as one column; the row counter wraps
        write_reg(REG_FRAME_WIDTH, 0);
        write_reg(REG_BOX_LEFT, 0);
        write_reg(REG_BOX_RIGHT, 0);
        write_reg(REG_BOX_TOP, 0);
        write_reg(REG_BOX_BOTTOM, 1);
        queue_frame(ROW_SPAN + 8, 1'b1, LUMA_RANDOM, MASK_MIXED);
      end else begin
        case ($urandom_range(5))
          0: w = 1;
          1: w = 2;
          default: w = $urandom_range(5, 10);
        endcase
        rows = $urandom_range(3, 7);
        write_reg(REG_FRAME_WIDTH, w);
        write_span(REG_BOX_LEFT, REG_BOX_RIGHT, w + 1);
        write_span(REG_BOX_TOP, REG_BOX_BOTTOM, rows);
        repeat ($urandom_range(1, 3)) begin
          n = w * rows + $urandom_range(0, w - 1);
          if ($urandom_range(9) == 0) n = $urandom_range(1, 2 * w);
          queue_frame(n, 1'b1, $urandom_range(3), $urandom_range(3));
        end
      end
    end

    wait_quiet();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // hang guard
  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

endmodule
